FILE: rtl/core/fifo_slot_dispatcher_macros.svh
// assertion macros for the fifo slot dispatcher
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef FIFO_SLOT_DISPATCHER_MACROS_SVH
`define FIFO_SLOT_DISPATCHER_MACROS_SVH
`ifndef NO_ASSERTIONS
// property that must hold at every clock edge outside reset
`define FSD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define FSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FSD_ASSERT(lbl, clk, rst_n, prop, msg)
`define FSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/core/fsd_pkg.sv
// shared types and constants of the fifo slot dispatcher
// no dependencies
package fsd_pkg;

    // default sizing
    localparam int PROCESSORS_DEF   = 2;
    localparam int CORES_EACH_DEF   = 2;
    localparam int THREADS_EACH_DEF = 2;
    localparam int FIFO_DEPTH_DEF   = 128;

    // field widths
    localparam int ID_W      = 16;
    localparam int LIFE_W    = 8;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;

    // register reset values
    localparam logic [CFG_W-1:0] QUEUE_LIMIT_RST     = 8'd100;
    localparam logic [CFG_W-1:0] ADMIT_PERIOD_RST    = 8'd2;
    localparam logic [CFG_W-1:0] DISPATCH_PERIOD_RST = 8'd3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUEUE_LIMIT     = 2'd0,
        CFG_ADMIT_PERIOD    = 2'd1,
        CFG_DISPATCH_PERIOD = 2'd2
    } t_cfg_idx;

    // one job as it waits in the queue or runs in a slot
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LIFE_W-1:0] life;
    } t_job;

    // command to the slot table
    typedef struct packed {
        logic age;
        logic load;
        t_job job;
    } t_slot_cmd;

    // status of the addressed slot
    typedef struct packed {
        logic busy;
        logic expired;
    } t_slot_stat;

endpackage

FILE: rtl/core/fifo_slot_dispatcher.sv
// fifo_slot_dispatcher: one tick item in, one result item out; stall is high while a tick is worked.
// a tick steps through accept, aging of every slot, admission and output; a dispatch tick also checks
// the slots after admission, with a queue head read before the first check and after each move.
// the slot table is walked one slot per cycle, but for those head reads, by a single sequencer; results
// wait in an output register so the next tick can be taken while the last result is stalled.
// reset (i_rst_n low, synchronous): slots idle, queue empty, next id 1, registers to defaults.
`include "fifo_slot_dispatcher_macros.svh"
module fifo_slot_dispatcher #(
    parameter int PROCESSORS   = fsd_pkg::PROCESSORS_DEF,
    parameter int CORES_EACH   = fsd_pkg::CORES_EACH_DEF,
    parameter int THREADS_EACH = fsd_pkg::THREADS_EACH_DEF,
    parameter int FIFO_DEPTH   = fsd_pkg::FIFO_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // tick input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [fsd_pkg::LIFE_W-1:0]       i_new_lifetime,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_admitted,
    output logic [fsd_pkg::ID_W-1:0]         o_admitted_id,
    output logic [3:0]                       o_dispatched_count,
    output logic [3:0]                       o_finished_count,
    output logic [3:0]                       o_running_count,
    output logic [7:0]                       o_waiting_count,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fsd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fsd_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int NSLOTS = PROCESSORS * CORES_EACH * THREADS_EACH;
    localparam int SLOT_W = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
    localparam int CNT_W  = ($clog2(NSLOTS + 1) > 4) ? $clog2(NSLOTS + 1) : 4;
    localparam int FILL_W = ($clog2(FIFO_DEPTH + 1) > 8) ? $clog2(FIFO_DEPTH + 1) : 8;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NSLOTS - 1);
    localparam int CW = fsd_pkg::CFG_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_AGE   = 6'b000010,
        ST_ADMIT = 6'b000100,
        ST_DWAIT = 6'b001000,
        ST_DSLOT = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    t_state                      r_state, n_state;
    logic [SLOT_W-1:0]           r_slot, n_slot;
    logic [fsd_pkg::LIFE_W-1:0]  r_life, n_life;
    logic [CNT_W-1:0]            r_fin, n_fin;
    logic [CNT_W-1:0]            r_dsp, n_dsp;
    logic [CNT_W-1:0]            r_busy, n_busy;
    logic                        r_adm, n_adm;
    logic [fsd_pkg::ID_W-1:0]    r_adm_id, n_adm_id;
    logic [fsd_pkg::ID_W-1:0]    r_next_id, n_next_id;
    logic [CW-1:0]               r_admit_ticks, n_admit_ticks;
    logic [CW-1:0]               r_dispatch_ticks, n_dispatch_ticks;
    logic [CW-1:0]               r_queue_limit;
    logic [CW-1:0]               r_admit_period;
    logic [CW-1:0]               r_dispatch_period;
    logic                        r_out_valid, n_out_valid;
    logic                        r_o_adm;
    logic [fsd_pkg::ID_W-1:0]    r_o_adm_id;
    logic [3:0]                  r_o_dsp, r_o_fin, r_o_run;
    logic [7:0]                  r_o_wait;

    logic                        in_acc;
    logic                        out_load;
    logic [CW:0]                 admit_sum, dispatch_sum;
    logic                        admit_fire, dispatch_fire;
    logic                        q_push, q_pop;
    fsd_pkg::t_job               q_push_data, q_head;
    logic [FILL_W-1:0]           q_fill;
    fsd_pkg::t_slot_cmd          slot_cmd;
    fsd_pkg::t_slot_stat         slot_stat;

    fsd_slots #(
        .NSLOTS (NSLOTS),
        .SLOT_W (SLOT_W)
    ) u_slots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_idx   (r_slot),
        .i_cmd   (slot_cmd),
        .o_stat  (slot_stat)
    );

    fsd_queue #(
        .DEPTH  (FIFO_DEPTH),
        .FILL_W (FILL_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_head_data (q_head),
        .o_fill      (q_fill)
    );

    // handshakes
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign out_load    = (r_state == ST_OUT) && (!r_out_valid || !i_out_stall);

    // period counters, both evaluated in the admission cycle
    assign admit_sum     = {1'b0, r_admit_ticks} + (CW + 1)'(1);
    assign dispatch_sum  = {1'b0, r_dispatch_ticks} + (CW + 1)'(1);
    assign admit_fire    = (admit_sum >= {1'b0, r_admit_period});
    assign dispatch_fire = (dispatch_sum >= {1'b0, r_dispatch_period});

    // sequencer
    always_comb begin
        n_state          = r_state;
        n_slot           = r_slot;
        n_life           = r_life;
        n_fin            = r_fin;
        n_dsp            = r_dsp;
        n_busy           = r_busy;
        n_adm            = r_adm;
        n_adm_id         = r_adm_id;
        n_next_id        = r_next_id;
        n_admit_ticks    = r_admit_ticks;
        n_dispatch_ticks = r_dispatch_ticks;
        q_push           = 1'b0;
        q_pop            = 1'b0;
        q_push_data.id   = r_next_id;
        q_push_data.life = r_life;
        slot_cmd.age     = 1'b0;
        slot_cmd.load    = 1'b0;
        slot_cmd.job     = q_head;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_life   = i_new_lifetime;
                    n_slot   = '0;
                    n_fin    = '0;
                    n_dsp    = '0;
                    n_adm    = 1'b0;
                    n_adm_id = '0;
                    n_state  = ST_AGE;
                end
            end
            ST_AGE: begin
                // one slot per cycle: free expired, decrement the rest
                slot_cmd.age = 1'b1;
                if (slot_stat.expired) begin
                    n_fin = r_fin + CNT_W'(1);
                    if (r_busy != '0) begin
                        n_busy = r_busy - CNT_W'(1);
                    end
                end
                if (r_slot == SLOT_LAST) begin
                    n_slot  = '0;
                    n_state = ST_ADMIT;
                end else begin
                    n_slot = r_slot + SLOT_W'(1);
                end
            end
            ST_ADMIT: begin
                n_admit_ticks    = admit_fire ? '0 : admit_sum[CW-1:0];
                n_dispatch_ticks = dispatch_fire ? '0 : dispatch_sum[CW-1:0];
                // limit is the smaller of the register and the queue depth
                if (admit_fire && (q_fill < {{(FILL_W - CW){1'b0}}, r_queue_limit})
                        && (q_fill < FILL_W'(FIFO_DEPTH))) begin
                    q_push    = 1'b1;
                    n_adm     = 1'b1;
                    n_adm_id  = r_next_id;
                    n_next_id = (r_next_id == '1) ? fsd_pkg::ID_W'(1)
                                                  : r_next_id + fsd_pkg::ID_W'(1);
                end
                n_state = dispatch_fire ? ST_DWAIT : ST_OUT;
            end
            ST_DWAIT: begin
                // queue head read settles
                n_state = ST_DSLOT;
            end
            ST_DSLOT: begin
                if (q_fill == '0) begin
                    n_state = ST_OUT;
                end else if (!slot_stat.busy) begin
                    slot_cmd.load = 1'b1;
                    q_pop         = 1'b1;
                    n_busy        = r_busy + CNT_W'(1);
                    n_dsp         = r_dsp + CNT_W'(1);
                    if (r_slot == SLOT_LAST) begin
                        n_state = ST_OUT;
                    end else begin
                        n_slot  = r_slot + SLOT_W'(1);
                        n_state = ST_DWAIT;
                    end
                end else if (r_slot == SLOT_LAST) begin
                    n_state = ST_OUT;
                end else begin
                    n_slot = r_slot + SLOT_W'(1);
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_busy           <= '0;
            r_next_id        <= fsd_pkg::ID_W'(1);
            r_admit_ticks    <= '0;
            r_dispatch_ticks <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state          <= n_state;
            r_busy           <= n_busy;
            r_next_id        <= n_next_id;
            r_admit_ticks    <= n_admit_ticks;
            r_dispatch_ticks <= n_dispatch_ticks;
            r_out_valid      <= n_out_valid;
        end
    end

    // per-tick working values
    always_ff @(posedge i_clk) begin
        r_slot   <= n_slot;
        r_life   <= n_life;
        r_fin    <= n_fin;
        r_dsp    <= n_dsp;
        r_adm    <= n_adm;
        r_adm_id <= n_adm_id;
    end

    // configuration registers, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_limit     <= fsd_pkg::QUEUE_LIMIT_RST;
            r_admit_period    <= fsd_pkg::ADMIT_PERIOD_RST;
            r_dispatch_period <= fsd_pkg::DISPATCH_PERIOD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                fsd_pkg::CFG_QUEUE_LIMIT:     r_queue_limit     <= i_cfg_data;
                fsd_pkg::CFG_ADMIT_PERIOD:    r_admit_period    <= i_cfg_data;
                fsd_pkg::CFG_DISPATCH_PERIOD: r_dispatch_period <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // result payload register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_adm    <= r_adm;
            r_o_adm_id <= r_adm_id;
            r_o_dsp    <= r_dsp[3:0];
            r_o_fin    <= r_fin[3:0];
            r_o_run    <= r_busy[3:0];
            r_o_wait   <= q_fill[7:0];
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_admitted         = r_o_adm;
    assign o_admitted_id      = r_o_adm_id;
    assign o_dispatched_count = r_o_dsp;
    assign o_finished_count   = r_o_fin;
    assign o_running_count    = r_o_run;
    assign o_waiting_count    = r_o_wait;

    // checks
    `FSD_ASSERT(a_busy_bound, i_clk, i_rst_n, r_busy <= CNT_W'(NSLOTS), "busy count above slots")
    `FSD_ASSERT(a_push_room, i_clk, i_rst_n, q_push |-> (q_fill < FILL_W'(FIFO_DEPTH)), "push into full queue")
    `FSD_ASSERT(a_pop_nonempty, i_clk, i_rst_n, q_pop |-> (q_fill != '0), "pop from empty queue")
    `FSD_ASSERT_NEXT(a_accept_ages, i_clk, i_rst_n, in_acc, r_state == ST_AGE, "accepted item not aging")

endmodule

FILE: rtl/core/fsd_slots.sv
// execution slot table: job id and remaining lifetime per slot
// depends on fsd_pkg
module fsd_slots #(
    parameter int NSLOTS = 8,
    parameter int SLOT_W = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [SLOT_W-1:0]     i_idx,
    input  fsd_pkg::t_slot_cmd    i_cmd,
    output fsd_pkg::t_slot_stat   o_stat
);

    logic [fsd_pkg::ID_W-1:0]   r_id   [NSLOTS];
    logic [fsd_pkg::LIFE_W-1:0] r_life [NSLOTS];

    // status of the slot under the sequencer index
    always_comb begin
        o_stat.busy    = (r_id[i_idx] != '0);
        o_stat.expired = (r_id[i_idx] != '0) && (r_life[i_idx] == '0);
    end

    // aging frees or decrements, load fills an idle slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NSLOTS; s++) begin
                r_id[s]   <= '0;
                r_life[s] <= '0;
            end
        end else if (i_cmd.load) begin
            r_id[i_idx]   <= i_cmd.job.id;
            r_life[i_idx] <= i_cmd.job.life;
        end else if (i_cmd.age && (r_id[i_idx] != '0)) begin
            if (r_life[i_idx] == '0) begin
                r_id[i_idx] <= '0;
            end else begin
                r_life[i_idx] <= r_life[i_idx] - fsd_pkg::LIFE_W'(1);
            end
        end
    end

endmodule

FILE: rtl/core/fsd_queue.sv
// waiting job fifo: one memory, head and tail pointers, fill count
// depends on fsd_pkg
module fsd_queue #(
    parameter int DEPTH  = 128,
    parameter int FILL_W = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  fsd_pkg::t_job       i_push_data,
    input  logic                i_pop,
    output fsd_pkg::t_job       o_head_data,
    output logic [FILL_W-1:0]   o_fill
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    fsd_pkg::t_job     r_mem [DEPTH];
    fsd_pkg::t_job     r_head_data;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [FILL_W-1:0] r_fill, n_fill;

    assign o_head_data = r_head_data;
    assign o_fill      = r_fill;

    // pointer and fill update, push and pop never coincide
    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        if (i_push) begin
            n_tail = (r_tail == PTR_LAST) ? '0 : r_tail + PTR_W'(1);
            n_fill = r_fill + FILL_W'(1);
        end else if (i_pop) begin
            n_head = (r_head == PTR_LAST) ? '0 : r_head + PTR_W'(1);
            n_fill = r_fill - FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    // storage, registered read of the head entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_push_data;
        end
        r_head_data <= r_mem[r_head];
    end

endmodule

FILE: tb/sv/tb_fifo_slot_dispatcher.sv
// testbench for fifo_slot_dispatcher: random and directed ticks checked against a tick-level
// prediction of slot aging, admission and dispatch; depends on fsd_pkg and the dispatcher rtl
`timescale 1ns / 100ps

module tb_fifo_slot_dispatcher;

    localparam int NSLOTS = fsd_pkg::PROCESSORS_DEF * fsd_pkg::CORES_EACH_DEF
                            * fsd_pkg::THREADS_EACH_DEF;
    localparam int QDEPTH = fsd_pkg::FIFO_DEPTH_DEF;

    // what one tick should report
    typedef struct {
        logic                      admitted;
        logic [fsd_pkg::ID_W-1:0]  admitted_id;
        logic [3:0]                dispatched;
        logic [3:0]                finished;
        logic [3:0]                running;
        logic [7:0]                waiting;
    } t_tick_report;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    // tick channel
    logic                        in_valid = 1'b0;
    logic [fsd_pkg::LIFE_W-1:0]  in_life  = '0;
    logic                        o_in_stall;

    // result channel
    logic                        out_stall = 1'b0;
    logic                        o_out_valid;
    logic                        o_admitted;
    logic [fsd_pkg::ID_W-1:0]    o_admitted_id;
    logic [3:0]                  o_dispatched_count;
    logic [3:0]                  o_finished_count;
    logic [3:0]                  o_running_count;
    logic [7:0]                  o_waiting_count;

    // register write channel
    logic                           cfg_valid = 1'b0;
    logic [fsd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [fsd_pkg::CFG_W-1:0]      cfg_data  = '0;
    logic                           o_cfg_ready;

    fifo_slot_dispatcher dut (
        .i_clk              (i_clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (o_in_stall),
        .i_new_lifetime     (in_life),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (out_stall),
        .o_admitted         (o_admitted),
        .o_admitted_id      (o_admitted_id),
        .o_dispatched_count (o_dispatched_count),
        .o_finished_count   (o_finished_count),
        .o_running_count    (o_running_count),
        .o_waiting_count    (o_waiting_count),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted block state
    logic [fsd_pkg::CFG_W-1:0]   queue_limit_reg;
    logic [fsd_pkg::CFG_W-1:0]   admit_period_reg;
    logic [fsd_pkg::CFG_W-1:0]   dispatch_period_reg;
    logic [fsd_pkg::ID_W-1:0]    slot_id   [NSLOTS];
    logic [fsd_pkg::LIFE_W-1:0]  slot_life [NSLOTS];
    logic [fsd_pkg::ID_W-1:0]    wait_id   [QDEPTH];
    logic [fsd_pkg::LIFE_W-1:0]  wait_life [QDEPTH];
    int                          wait_head;
    int                          wait_tail;
    int                          wait_fill;
    int                          busy_slots;
    logic [fsd_pkg::ID_W-1:0]    next_id;
    logic [7:0]                  admit_count;
    logic [7:0]                  dispatch_count;

    logic [fsd_pkg::LIFE_W-1:0]  pending_lifetimes [$];
    t_tick_report                expected_reports [$];
    int                          errors = 0;

    // traffic shaping
    int hold_requests  = 0;

    // period counter: fires once the incremented count reaches the period
    function automatic bit period_hit(ref logic [7:0] count, input logic [7:0] period);
        int c;
        c = int'(count) + 1;
        if (c >= int'(period)) begin
            count = '0;
            return 1'b1;
        end
        count = 8'(c);
        return 1'b0;
    endfunction

    // one tick: age slots, then admit, then dispatch
    function automatic t_tick_report advance_tick(logic [fsd_pkg::LIFE_W-1:0] life);
        t_tick_report rep;
        int finished;
        int dispatched;
        int limit;
        finished   = 0;
        dispatched = 0;
        rep.admitted    = 1'b0;
        rep.admitted_id = '0;
        for (int s = 0; s < NSLOTS; s++) begin
            if (slot_id[s] != '0) begin
                if (slot_life[s] == '0) begin
                    slot_id[s] = '0;
                    finished++;
                    if (busy_slots > 0) busy_slots--;
                end else begin
                    slot_life[s] = slot_life[s] - 1'b1;
                end
            end
        end
        if (period_hit(admit_count, admit_period_reg)) begin
            limit = (int'(queue_limit_reg) > QDEPTH) ? QDEPTH : int'(queue_limit_reg);
            if (wait_fill < limit) begin
                wait_id[wait_tail]   = next_id;
                wait_life[wait_tail] = life;
                wait_tail            = (wait_tail + 1) % QDEPTH;
                wait_fill++;
                rep.admitted    = 1'b1;
                rep.admitted_id = next_id;
                next_id         = next_id + 1'b1;
                if (next_id == '0) begin
                    next_id = 16'd1;
                end
            end
        end
        if (period_hit(dispatch_count, dispatch_period_reg)) begin
            for (int s = 0; s < NSLOTS && wait_fill > 0; s++) begin
                if (slot_id[s] == '0) begin
                    slot_id[s]   = wait_id[wait_head];
                    slot_life[s] = wait_life[wait_head];
                    wait_head    = (wait_head + 1) % QDEPTH;
                    wait_fill--;
                    busy_slots++;
                    dispatched++;
                end
            end
        end
        rep.dispatched = 4'(dispatched);
        rep.finished   = 4'(finished);
        rep.running    = 4'(busy_slots);
        rep.waiting    = 8'(wait_fill);
        return rep;
    endfunction

    // tick sender: bursts of items with random gaps, fed from the pending queue
    int burst_left = 1;
    int gap_left   = 0;
    always @(posedge i_clk) begin
        logic                        next_valid;
        logic [fsd_pkg::LIFE_W-1:0]  next_life;
        next_valid = in_valid;
        next_life  = in_life;
        if (rst_n) begin
            if (in_valid && !o_in_stall) begin
                expected_reports.push_back(advance_tick(in_life));
                next_valid = 1'b0;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    if ($urandom_range(0, 3) == 0)
                        gap_left = $urandom_range(1, 25);
                    else
                        gap_left = $urandom_range(0, 2);
                end
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_lifetimes.size() != 0) begin
                    next_valid = 1'b1;
                    next_life  = pending_lifetimes.pop_front();
                end
            end
        end
        in_valid <= next_valid;
        in_life  <= next_life;
    end

    // result receiver: random stall patterns, plus long hold-offs
    int pattern_mode = 0;
    int pattern_left = 0;
    int hold_starts  = 0;
    int hold_left    = 0;
    always @(posedge i_clk) begin
        logic next_stall;
        if (pattern_left == 0) begin
            pattern_mode = $urandom_range(0, 3);
            pattern_left = $urandom_range(16, 96);
        end else begin
            pattern_left--;
        end
        if (hold_starts != hold_requests) begin
            hold_starts++;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            next_stall = 1'b1;
        end else begin
            case (pattern_mode)
                0:       next_stall = 1'b0;
                1:       next_stall = ($urandom_range(0, 2) == 0);
                2:       next_stall = ($urandom_range(0, 3) != 0);
                default: next_stall = !out_stall;
            endcase
        end
        if (!rst_n) next_stall = 1'b0;
        out_stall <= next_stall;
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // result monitor: compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_tick_report want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (expected_reports.size() == 0) begin
                $error("result with no tick awaiting it");
                errors++;
            end else begin
                want = expected_reports.pop_front();
                check_field("admitted", want.admitted, o_admitted);
                check_field("admitted_id", want.admitted_id, o_admitted_id);
                check_field("dispatched_count", want.dispatched, o_dispatched_count);
                check_field("finished_count", want.finished, o_finished_count);
                check_field("running_count", want.running, o_running_count);
                check_field("waiting_count", want.waiting, o_waiting_count);
            end
        end
    end

    // register write, only issued while the block is idle
    task automatic write_reg(fsd_pkg::t_cfg_idx idx, logic [fsd_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            fsd_pkg::CFG_QUEUE_LIMIT:     queue_limit_reg     = val;
            fsd_pkg::CFG_ADMIT_PERIOD:    admit_period_reg    = val;
            fsd_pkg::CFG_DISPATCH_PERIOD: dispatch_period_reg = val;
            default: ;
        endcase
    endtask

    task automatic set_registers(logic [7:0] limit, logic [7:0] admit, logic [7:0] dispatch);
        write_reg(fsd_pkg::CFG_QUEUE_LIMIT, limit);
        write_reg(fsd_pkg::CFG_ADMIT_PERIOD, admit);
        write_reg(fsd_pkg::CFG_DISPATCH_PERIOD, dispatch);
    endtask

    // every tick sent and every result back
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_lifetimes.size() != 0 || in_valid || expected_reports.size() != 0);
    endtask

    logic [fsd_pkg::LIFE_W-1:0] opening_lives [12] = '{8'd0, 8'd0, 8'd255, 8'd1, 8'h55, 8'hAA,
                                                        8'd0, 8'd2, 8'd255, 8'd0, 8'd3, 8'h80};
    logic [fsd_pkg::LIFE_W-1:0] idle_lives [5]     = '{8'd255, 8'd0, 8'hF0, 8'h0F, 8'd7};

    initial begin
        int                          n_ticks;
        logic [7:0]                  lim;
        logic [7:0]                  adm;
        logic [7:0]                  dsp;
        logic [fsd_pkg::LIFE_W-1:0]  life;

        // state after reset
        queue_limit_reg     = fsd_pkg::QUEUE_LIMIT_RST;
        admit_period_reg    = fsd_pkg::ADMIT_PERIOD_RST;
        dispatch_period_reg = fsd_pkg::DISPATCH_PERIOD_RST;
        foreach (slot_id[s]) begin
            slot_id[s]   = '0;
            slot_life[s] = '0;
        end
        wait_head      = 0;
        wait_tail      = 0;
        wait_fill      = 0;
        busy_slots     = 0;
        next_id        = 16'd1;
        admit_count    = '0;
        dispatch_count = '0;

        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;

        // directed: reset periods, lifetime extremes and zero lifetimes
        @(negedge i_clk);
        foreach (opening_lives[k]) pending_lifetimes.push_back(opening_lives[k]);
        wait_idle();

        // zero limit blocks admission, periods of 0 and 1 fire every tick
        set_registers(8'd0, 8'd0, 8'd1);
        foreach (idle_lives[k]) pending_lifetimes.push_back(idle_lives[k]);
        wait_idle();

        // small limit reached, then dispatch period dropped below its running count
        set_registers(8'd4, 8'd1, 8'd200);
        repeat (8) pending_lifetimes.push_back(8'($urandom_range(0, 255)));
        wait_idle();
        write_reg(fsd_pkg::CFG_DISPATCH_PERIOD, 8'd1);
        pending_lifetimes.push_back(8'd0);
        pending_lifetimes.push_back(8'd255);
        wait_idle();

        // random phases, extremes first
        for (int p = 0; p < 10; p++) begin
            n_ticks = 80;
            case (p)
                0: begin lim = 8'd255; adm = 8'd1;   dsp = 8'd255; n_ticks = 150; end
                1: begin lim = 8'd128; adm = 8'd0;   dsp = 8'd1;   n_ticks = 100; end
                2: begin lim = 8'd1;   adm = 8'd3;   dsp = 8'd2;   n_ticks = 60;  end
                3: begin lim = 8'd0;   adm = 8'd255; dsp = 8'd0;   n_ticks = 40;  end
                default: begin
                    lim = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(1, 24));
                    adm = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(0, 5));
                    dsp = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(0, 8));
                end
            endcase
            set_registers(lim, adm, dsp);
            if (p == 1) hold_requests++;
            repeat (n_ticks) begin
                case ($urandom_range(0, 3))
                    0:       life = '0;
                    1:       life = 8'($urandom_range(1, 8));
                    2:       life = 8'd255;
                    default: life = 8'($urandom_range(0, 255));
                endcase
                pending_lifetimes.push_back(life);
            end
            wait_idle();
        end

        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("** fifo_slot_dispatcher: PASSED **");
        else
            $display("** fifo_slot_dispatcher: FAILED **");
        $finish;
    end

    // run limit
    initial begin
        #100_000_000;
        $display("** fifo_slot_dispatcher: FAILED **");
        $finish;
    end

endmodule
